FILE: design/frw_pkg.sv
// ----------------------------------------------------------------------------
// frw_pkg
// Types, constants and helpers shared by the retransmit window modules.
// ----------------------------------------------------------------------------
package frw_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = $clog2(2 * WINDOW_DEPTH);
	localparam int FRAME_W = 32;
	localparam int DIFF_W = FRAME_W + 1;
	localparam int WORD_W = 64;
	localparam int OFFSET_W = 6;
	localparam int TICKS_W = 16;
	localparam int OP_W = 2;
	localparam int IN_DATA_W = 96;
	localparam int OUT_DATA_W = 104;
	localparam logic [TICKS_W-1:0] RETRY_TICKS_RESET = TICKS_W'(100);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_ACK   = 2'd1,
		OP_TICK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic {
		REG_ENABLED     = 1'b0,
		REG_RETRY_TICKS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_APPLY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               enabled;
		logic [TICKS_W-1:0] retry_ticks;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} ram_req_t;

	// slot = (a + b) mod depth, with a + b below twice the depth
	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(WINDOW_DEPTH)) ? s - SUM_W'(WINDOW_DEPTH) : s;
		return r[SLOT_W-1:0];
	endfunction

endpackage

FILE: design/frame_input_retransmit_window.sv
// ----------------------------------------------------------------------------
// frame_input_retransmit_window
// Sliding retransmit window of per-frame 64-bit input words.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. Push, acknowledge, clear and a tick
// that sends nothing each pass through accept, frame offset subtract and
// window update. A tick that sends then reads the run of held entries from
// the word store through its single registered read port at one entry per
// cycle while the sink is ready. The next command is accepted as soon as the
// last read of a run is issued, while the final beat may still wait on the
// master side. The word store is never cleared; only written entries are read.
// ----------------------------------------------------------------------------
module frame_input_retransmit_window (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [frw_pkg::TICKS_W-1:0]      cfg_data,
	// command stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [frw_pkg::IN_DATA_W-1:0]    s_tdata,   // frame_number[31:0], input_word[95:32]
	input  logic [frw_pkg::OP_W-1:0]         s_tuser,   // opcode[1:0]
	// window run stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [frw_pkg::OUT_DATA_W-1:0]   m_tdata,   // window_start[31:0], entry_offset[37:32],
	                                                    // entry_word[101:38], zero pad[103:102]
	output logic                             m_tlast    // last_entry
);
	import frw_pkg::*;

	cfg_t                cfg_q;
	ram_req_t            ram_req;
	logic [WORD_W-1:0]   rd_word;
	logic [FRAME_W-1:0]  out_start;
	logic [OFFSET_W-1:0] out_offset;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled     <= 1'b0;
			cfg_q.retry_ticks <= RETRY_TICKS_RESET;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLED:     cfg_q.enabled     <= cfg_data[0];
				REG_RETRY_TICKS: cfg_q.retry_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	frw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (op_t'(s_tuser)),
		.in_frame   (s_tdata[FRAME_W-1:0]),
		.in_word    (s_tdata[FRAME_W +: WORD_W]),
		.ram_req    (ram_req),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_start  (out_start),
		.out_offset (out_offset),
		.out_last   (m_tlast)
	);

	frw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WINDOW_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rd_word)
	);

	assign m_tdata = {2'b00, rd_word, out_offset, out_start};

endmodule

FILE: design/frw_ram.sv
// ----------------------------------------------------------------------------
// frw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/frw_ctrl.sv
// ----------------------------------------------------------------------------
// frw_ctrl
// Window sequencer: offset compute, state update, store writes and run reads.
// ----------------------------------------------------------------------------
module frw_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  frw_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  frw_pkg::op_t                   in_op,
	input  logic [frw_pkg::FRAME_W-1:0]    in_frame,
	input  logic [frw_pkg::WORD_W-1:0]     in_word,
	output frw_pkg::ram_req_t              ram_req,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [frw_pkg::FRAME_W-1:0]    out_start,
	output logic [frw_pkg::OFFSET_W-1:0]   out_offset,
	output logic                           out_last
);
	import frw_pkg::*;

	state_t              state_q, state_d;
	op_t                 op_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [WORD_W-1:0]   word_q;
	logic [DIFF_W-1:0]   d_s1;

	logic [FRAME_W-1:0]  start_q;
	logic [COUNT_W-1:0]  held_q;
	logic [SLOT_W-1:0]   head_q;
	logic                changed_q;
	logic [TICKS_W-1:0]  countdown_q;
	logic [COUNT_W-1:0]  k_q;
	logic                valid_q;

	logic                d_neg, d_pos, d_lt_h, d_gt_h;
	logic [COUNT_W-1:0]  d_small;
	logic [COUNT_W-1:0]  h1;
	logic                restart;
	logic [TICKS_W-1:0]  cd_dec;
	logic                send;
	logic                issue;
	logic                k_last;
	logic [COUNT_W-1:0]  ack_n;

	assign d_neg   = d_s1[DIFF_W-1];
	assign d_pos   = !d_neg && (d_s1 != '0);
	assign d_lt_h  = d_neg || (d_s1 < DIFF_W'(held_q));
	assign d_gt_h  = !d_neg && (d_s1 > DIFF_W'(held_q));
	assign d_small = d_s1[COUNT_W-1:0];
	assign h1      = ((held_q != '0) && d_lt_h) ? (d_pos ? d_small : '0) : held_q;
	assign restart = (h1 == '0) || d_gt_h;
	assign ack_n   = d_lt_h ? d_small : held_q;
	assign cd_dec  = (countdown_q != '0) ? countdown_q - 1'b1 : countdown_q;
	assign send    = (held_q != '0) && (changed_q || (cd_dec == '0));
	assign k_last  = (k_q + 1'b1) == held_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = (op_q == OP_TICK && send) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (issue && k_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		issue         = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = restart ? '0 : wrap_slot(SUM_W'(head_q) + SUM_W'(h1));
		ram_req.wdata = word_q;
		ram_req.raddr = wrap_slot(SUM_W'(head_q) + SUM_W'(k_q));
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_APPLY: begin
				ram_req.we = (op_q == OP_PUSH) && cfg.enabled && !d_neg;
			end
			ST_EMIT: begin
				issue = !valid_q || out_ready;
			end
			default: begin
			end
		endcase
		ram_req.re = issue;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q    <= in_op;
			frame_q <= in_frame;
			word_q  <= in_word;
		end
		if (state_q == ST_EVAL) begin
			d_s1 <= {frame_q[FRAME_W-1], frame_q} - {start_q[FRAME_W-1], start_q};
		end
		if (issue) begin
			out_start  <= start_q;
			out_offset <= OFFSET_W'(k_q);
			out_last   <= k_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			held_q      <= '0;
			head_q      <= '0;
			changed_q   <= 1'b0;
			countdown_q <= '0;
			k_q         <= '0;
			valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				valid_q <= 1'b1;
				k_q     <= k_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (state_q == ST_APPLY) begin
				k_q <= '0;
				case (op_q)
					OP_PUSH: begin
						if (cfg.enabled) begin
							if (d_neg) begin
								held_q <= h1;
							end else begin
								changed_q <= 1'b1;
								if (restart) begin
									start_q <= frame_q;
									if (WINDOW_DEPTH == 1) begin
										held_q <= COUNT_W'(1);
										head_q <= '0;
									end else begin
										held_q <= COUNT_W'(1);
										head_q <= '0;
									end
								end else if (h1 == COUNT_W'(WINDOW_DEPTH)) begin
									head_q  <= wrap_slot(SUM_W'(head_q) + SUM_W'(1));
									start_q <= start_q + 1'b1;
									held_q  <= h1;
								end else begin
									held_q <= h1 + 1'b1;
								end
							end
						end
					end
					OP_ACK: begin
						if (held_q != '0 && d_pos) begin
							head_q  <= wrap_slot(SUM_W'(head_q) + SUM_W'(ack_n));
							start_q <= start_q + FRAME_W'(ack_n);
							held_q  <= held_q - ack_n;
						end
					end
					OP_TICK: begin
						if (send) begin
							changed_q   <= 1'b0;
							countdown_q <= cfg.retry_ticks;
						end else begin
							countdown_q <= cd_dec;
						end
					end
					OP_CLEAR: begin
						held_q    <= '0;
						head_q    <= '0;
						start_q   <= '0;
						changed_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid = valid_q;

endmodule

FILE: tb/sv/window_run_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_run_checker
// Watches the config, command and run streams of the retransmit window.
// Each accepted command is applied to a local copy of the window. A tick
// that sends queues the beats of the run. Each run beat is compared field by
// field against the oldest queued beat.
// ----------------------------------------------------------------------------
module window_run_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [frw_pkg::TICKS_W-1:0]    cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [frw_pkg::IN_DATA_W-1:0]  s_tdata,   // frame_number[31:0], input_word[95:32]
	input  logic [frw_pkg::OP_W-1:0]       s_tuser,   // opcode[1:0]
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [frw_pkg::OUT_DATA_W-1:0] m_tdata,   // window_start[31:0],
	                                                  // entry_offset[37:32],
	                                                  // entry_word[101:38],
	                                                  // zero pad[103:102]
	input  logic                           m_tlast,   // last_entry
	output int                             fail_count,
	output int                             pending
);
	import frw_pkg::*;

	localparam int DEPTH = WINDOW_DEPTH;

	typedef struct {
		logic [FRAME_W-1:0]  start;
		logic [OFFSET_W-1:0] offset;
		logic [WORD_W-1:0]   word;
		logic                last;
	} run_beat_t;

	run_beat_t          run_beats_q[$];

	// local copy of the window
	logic [FRAME_W-1:0] win_start = '0;
	int                 held = 0;
	int                 head = 0;
	logic [WORD_W-1:0]  word_mem [DEPTH];
	bit                 changed = 1'b0;
	logic [TICKS_W-1:0] countdown = '0;
	bit                 enabled = 1'b0;
	logic [TICKS_W-1:0] retry_ticks = RETRY_TICKS_RESET;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic window_push(longint f, logic [WORD_W-1:0] word);
		longint first;
		longint nxt;
		first = longint'($signed(win_start));
		nxt = first + held;
		if (held > 0 && f < nxt)
			held = (f > first) ? int'(f - first) : 0;
		nxt = first + held;
		if (f < first)
			return;
		if (held == 0 || f > nxt) begin
			held = 0;
			head = 0;
			win_start = f[FRAME_W-1:0];
		end
		word_mem[(head + held) % DEPTH] = word;
		held++;
		changed = 1'b1;
		if (held > DEPTH) begin
			head = (head + 1) % DEPTH;
			win_start = win_start + 1;
			held--;
		end
	endtask

	task automatic window_ack(longint a);
		longint first;
		int n;
		first = longint'($signed(win_start));
		if (held == 0 || a <= first)
			return;
		n = (a - first < held) ? int'(a - first) : held;
		head = (head + n) % DEPTH;
		win_start = win_start + n;
		held -= n;
	endtask

	task automatic window_tick();
		run_beat_t b;
		if (countdown > 0)
			countdown--;
		if (held == 0 || (!changed && countdown != 0))
			return;
		for (int k = 0; k < held; k++) begin
			b.start = win_start;
			b.offset = k[OFFSET_W-1:0];
			b.word = word_mem[(head + k) % DEPTH];
			b.last = (k == held - 1);
			run_beats_q.insert(run_beats_q.size(), b);
		end
		changed = 1'b0;
		countdown = retry_ticks;
	endtask

	task automatic apply_command(op_t op, logic [FRAME_W-1:0] frame, logic [WORD_W-1:0] word);
		case (op)
		OP_PUSH: if (enabled) window_push(longint'($signed(frame)), word);
		OP_ACK:  window_ack(longint'($signed(frame)));
		OP_TICK: window_tick();
		OP_CLEAR: begin
			held = 0;
			head = 0;
			win_start = '0;
			changed = 1'b0;
		end
		default: begin
		end
		endcase
	endtask

	task automatic check_beat();
		run_beat_t b;
		if (run_beats_q.size() == 0) begin
			report_mismatch("run beat with nothing pending, entry_word", m_tdata[101:38], '0);
			return;
		end
		b = run_beats_q[0];
		run_beats_q.delete(0);
		if (m_tdata[31:0] !== b.start)
			report_mismatch("window_start", 64'(m_tdata[31:0]), 64'(b.start));
		if (m_tdata[37:32] !== b.offset)
			report_mismatch("entry_offset", 64'(m_tdata[37:32]), 64'(b.offset));
		if (m_tdata[101:38] !== b.word)
			report_mismatch("entry_word", m_tdata[101:38], b.word);
		if (m_tlast !== b.last)
			report_mismatch("last_entry", 64'(m_tlast), 64'(b.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start = '0;
			held = 0;
			head = 0;
			changed = 1'b0;
			countdown = '0;
			enabled = 1'b0;
			retry_ticks = RETRY_TICKS_RESET;
			run_beats_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ENABLED)
					enabled = cfg_data[0];
				else
					retry_ticks = cfg_data;
			end
			// beat first: a new tick's run is queued behind the one draining
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready)
				apply_command(op_t'(s_tuser), s_tdata[31:0], s_tdata[95:32]);
		end
		pending = run_beats_q.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the frame input retransmit window.
// A directed part walks disabled pushes, tail rewrites, stale frames, gaps,
// acks, clears, retry expiry, a zero retry interval and window overflow.
// Random game-like traffic follows over several register settings, with
// bursty commands and a stalling run sink. A checker module does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
	import frw_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = 1'b0;
	logic [TICKS_W-1:0]    cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // frame_number[31:0], input_word[95:32]
	logic [OP_W-1:0]       s_tuser = '0;   // opcode[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // window_start[31:0], entry_offset[37:32],
	                                       // entry_word[101:38], zero pad[103:102]
	logic                  m_tlast;        // last_entry

	int fail_count;
	int pending;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	frame_input_retransmit_window uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	window_run_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run sink: phases of always ready, coin flip, and mostly stalled
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(2);
			stall_left = $urandom_range(200, 20);
		end
		stall_left--;
		case (stall_mode)
		0: m_tready <= 1'b1;
		1: m_tready <= 1'($urandom_range(1));
		default: m_tready <= ($urandom_range(3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_cmd(op_t op, logic [31:0] frame, logic [63:0] word);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(3) == 0) begin
				burst_left = $urandom_range(60, 30);
				gap = 0;
			end else begin
				burst_left = $urandom_range(12, 1);
				gap = $urandom_range(15);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {word, frame};
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic drain_and_pause();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(bit en, logic [15:0] ticks);
		cfg_valid <= 1'b1;
		cfg_index <= REG_RETRY_TICKS;
		cfg_data <= ticks;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_ENABLED;
		cfg_data <= {15'd0, en};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// game-like traffic: mostly in-order pushes with rollbacks, lagging acks
	// and periodic ticks; some gaps, clears and pure noise
	task automatic run_traffic(int count);
		logic [31:0] cur;
		logic [31:0] f;
		int roll;
		cur = $urandom;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				case ($urandom_range(2))
				0: cur = 32'h7FFF_FFF0 + $urandom_range(15);
				1: cur = 32'h8000_0000 + $urandom_range(15);
				default: cur = $urandom;
				endcase
				roll = 0;
			end
			if (roll < 48) begin
				send_cmd(OP_PUSH, cur, {$urandom, $urandom});
				cur++;
			end else if (roll < 58) begin
				f = cur - $urandom_range(3, 1);
				send_cmd(OP_PUSH, f, {$urandom, $urandom});
				cur = f + 1;
			end else if (roll < 73) begin
				send_cmd(OP_TICK, $urandom, {$urandom, $urandom});
			end else if (roll < 85) begin
				send_cmd(OP_ACK, cur - $urandom_range(8), {$urandom, $urandom});
			end else if (roll < 90) begin
				f = cur + $urandom_range(10, 2);
				send_cmd(OP_PUSH, f, {$urandom, $urandom});
				cur = f + 1;
			end else if (roll < 93) begin
				send_cmd(OP_CLEAR, $urandom, {$urandom, $urandom});
			end else begin
				send_cmd(op_t'($urandom_range(3)), $urandom, {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		logic [31:0] base;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: disabled, so the push is dropped
		send_cmd(OP_PUSH, 32'd5, 64'hDEAD_BEEF_0123_4567);
		send_cmd(OP_TICK, 32'd0, 64'd0);
		send_cmd(OP_ACK, 32'd3, 64'd0);
		drain_and_pause();
		configure(1'b1, 16'd2);

		send_cmd(OP_PUSH, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(OP_PUSH, 32'h8000_0001, 64'd0);
		send_cmd(OP_TICK, 32'd0, 64'd0);
		send_cmd(OP_TICK, 32'd0, 64'd0);
		send_cmd(OP_TICK, 32'd0, 64'd0);    // countdown expired: resend
		send_cmd(OP_PUSH, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001);
		send_cmd(OP_PUSH, 32'h7FFF_FFFE, 64'h5555_5555_5555_5555);    // stale: empties
		send_cmd(OP_TICK, 32'd0, 64'd0);
		send_cmd(OP_PUSH, 32'd10, 64'hAAAA_AAAA_AAAA_AAAA);
		send_cmd(OP_PUSH, 32'd11, 64'h1111_2222_3333_4444);
		send_cmd(OP_PUSH, 32'd12, 64'h0F0F_0F0F_0F0F_0F0F);
		send_cmd(OP_PUSH, 32'd11, 64'hF0F0_F0F0_F0F0_F0F0);    // tail rewrite
		send_cmd(OP_TICK, 32'd0, 64'd0);
		send_cmd(OP_PUSH, 32'd20, 64'h0123_4567_89AB_CDEF);    // gap
		send_cmd(OP_PUSH, 32'd21, 64'hFEDC_BA98_7654_3210);
		send_cmd(OP_ACK, 32'd20, 64'd0);
		send_cmd(OP_ACK, 32'd21, 64'd0);
		send_cmd(OP_TICK, 32'd0, 64'd0);
		send_cmd(OP_ACK, 32'h7FFF_FFFF, 64'd0);    // beyond the window
		send_cmd(OP_PUSH, 32'd23, 64'h0000_0000_0000_0001);
		send_cmd(OP_CLEAR, 32'd0, 64'd0);
		send_cmd(OP_TICK, 32'd0, 64'd0);
		drain_and_pause();

		// zero retry interval: every tick resends
		configure(1'b1, 16'd0);
		send_cmd(OP_PUSH, 32'hFFFF_FFFF, 64'hC3C3_C3C3_C3C3_C3C3);
		send_cmd(OP_TICK, 32'd0, 64'd0);
		send_cmd(OP_TICK, 32'd0, 64'd0);
		drain_and_pause();

		// overflow past the capacity
		configure(1'b1, 16'hFFFF);
		base = $urandom;
		for (int k = 0; k < WINDOW_DEPTH + 6; k++)
			send_cmd(OP_PUSH, base + k, {$urandom, $urandom});
		send_cmd(OP_TICK, 32'd0, 64'd0);
		send_cmd(OP_TICK, 32'd0, 64'd0);

		for (int p = 0; p < 6; p++) begin
			drain_and_pause();
			case (p)
			0: configure(1'b1, 16'd1);
			1: configure(1'b0, 16'($urandom));
			2: configure(1'b1, 16'hFFFF);
			3: configure(1'b1, 16'($urandom_range(8, 2)));
			4: configure(1'b1, 16'd0);
			default: configure(1'b1, 16'd100);
			endcase
			run_traffic((p == 1) ? 30 : 60);
		end

		drain_and_pause();
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/frw_pkg.sv
design/frw_ram.sv
design/frw_ctrl.sv
design/frame_input_retransmit_window.sv
tb/sv/window_run_checker.sv
tb/sv/tb_top.sv
